/* rtl/brwt_pkg.sv */
// Shared constants and helpers for the byte RAM with timer port.
`timescale 1ns / 1ps

package brwt_pkg;

    localparam int LANES       = 4;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 40;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    typedef logic [7:0] t_byte;

    function automatic logic [2:0] byte_count(input logic [1:0] size);
        logic [2:0] n;
        unique case (size)
            SIZE_BYTE: n = 3'd1;
            SIZE_HALF: n = 3'd2;
            default:   n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

/* rtl/byte_ram_with_timer_mmio_top.sv */
// Top level of the little-endian byte RAM with memory-mapped timer and stop flag.
`timescale 1ns / 1ps

// Accepts one read, write or counter-load transaction and returns one result per
// transaction. An item first decodes the bytes and accesses four byte-wide bank
// RAMs, then assembles the registered bank read data into the output register;
// the next item is accepted once the previous one has reached the output
// register, even while its result still waits there. After reset a clearing
// pass zeroes all ceil(RAM_BYTES/4) rows of the RAM, one row of four bytes per
// cycle, during which no transaction is accepted; timer address writes on the
// config channel are always taken.
module byte_ram_with_timer_mmio_top #(
    parameter int RAM_BYTES = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [31:0]                        i_cfg_data,   // timer_address
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // address[31:0], access_size[33:32], write_data[65:34], cycle_value[129:66], zero pad
    input  logic [brwt_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic [1:0]                         i_s_axis_tuser, // kind
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // read_data[31:0], stopped[32], zero pad
    output logic [brwt_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int ROWS  = (RAM_BYTES + 3) / 4;
    localparam int ROW_W = ROWS > 1 ? $clog2(ROWS) : 1;

    logic [31:0] r_timer;
    logic [63:0] r_cycle;
    logic        r_stop;
    logic        r_clearing;
    logic [ROW_W-1:0] r_clr_row;
    logic        r_busy;
    logic [1:0]  r_base;
    logic [3:0]  r_use;
    brwt_pkg::t_byte r_byte [brwt_pkg::LANES];
    logic        r_ovalid;
    logic [31:0] r_rdata;
    logic        r_ostop;

    logic [1:0]  in_kind;
    logic [31:0] in_addr;
    logic [1:0]  in_size;
    logic [31:0] in_wdata;
    logic [63:0] in_cycle;
    logic        in_acc;
    logic        done;
    logic [2:0]  n_bytes;

    logic [3:0]       ram_we;
    logic [3:0]       ram_re;
    logic [ROW_W-1:0] ram_addr  [brwt_pkg::LANES];
    brwt_pkg::t_byte  ram_wdata [brwt_pkg::LANES];
    brwt_pkg::t_byte  ram_q     [brwt_pkg::LANES];
    logic [3:0]       n_use;
    brwt_pkg::t_byte  n_byte    [brwt_pkg::LANES];
    logic             stop_hit;
    logic [31:0]      n_rdata;

    assign in_addr  = i_s_axis_tdata[31:0];
    assign in_size  = i_s_axis_tdata[33:32];
    assign in_wdata = i_s_axis_tdata[65:34];
    assign in_cycle = i_s_axis_tdata[129:66];
    assign in_kind  = i_s_axis_tuser;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_clearing && !r_busy;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign done            = r_busy && (!r_ovalid || i_m_axis_tready);
    assign n_bytes         = brwt_pkg::byte_count(in_size);

    always_comb begin
        logic [1:0]  off;
        logic [31:0] a;
        logic [31:0] t;
        logic        active;
        logic        in_ram;
        stop_hit = 1'b0;
        for (int b = 0; b < brwt_pkg::LANES; b++) begin
            off    = 2'(b) - in_addr[1:0];
            a      = in_addr + 32'(off);
            t      = a - r_timer;
            active = {1'b0, off} < n_bytes;
            in_ram = a < 32'(RAM_BYTES);
            n_use[b]  = (in_kind == brwt_pkg::KIND_READ) && active && in_ram;
            n_byte[b] = ((in_kind == brwt_pkg::KIND_READ) && active && !in_ram && t < 32'd4)
                        ? r_cycle[{t[1:0], 3'b000} +: 8] : 8'h00;
            if ((in_kind == brwt_pkg::KIND_WRITE) && active && !in_ram && a == r_timer) begin
                stop_hit = 1'b1;
            end
            if (r_clearing) begin
                ram_we[b]    = 1'b1;
                ram_re[b]    = 1'b0;
                ram_addr[b]  = r_clr_row;
                ram_wdata[b] = 8'h00;
            end else begin
                ram_we[b]    = in_acc && (in_kind == brwt_pkg::KIND_WRITE) && active && in_ram;
                ram_re[b]    = in_acc && n_use[b];
                ram_addr[b]  = a[ROW_W+1:2];
                ram_wdata[b] = in_wdata[{off, 3'b000} +: 8];
            end
        end
    end

    for (genvar g = 0; g < brwt_pkg::LANES; g++) begin : g_bank
        brwt_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_re    (ram_re[g]),
            .i_addr  (ram_addr[g]),
            .i_wdata (ram_wdata[g]),
            .o_rdata (ram_q[g])
        );
    end

    always_comb begin
        logic [1:0] sel;
        for (int i = 0; i < brwt_pkg::LANES; i++) begin
            sel = r_base + 2'(i);
            n_rdata[i*8 +: 8] = r_use[sel] ? ram_q[sel] : r_byte[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer    <= 32'h1000_0000;
            r_cycle    <= 64'd0;
            r_stop     <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
            r_busy     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timer <= i_cfg_data;
            end
            if (r_clearing) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_acc) begin
                r_busy <= 1'b1;
                if (in_kind == brwt_pkg::KIND_LOAD) begin
                    r_cycle <= in_cycle;
                end
                if (stop_hit) begin
                    r_stop <= 1'b1;
                end
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_base <= in_addr[1:0];
            r_use  <= n_use;
            r_byte <= n_byte;
        end
        if (done) begin
            r_rdata <= n_rdata;
            r_ostop <= r_stop;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_ostop, r_rdata};

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_acc)
        else $error("transaction accepted during RAM clearing");

    a_busy_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_ovalid && !r_busy)
        else $error("pending transaction did not reach output register");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |=> r_stop)
        else $error("stop flag cleared without reset");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy || r_ovalid)
        else $error("accepted transaction lost");
`endif

endmodule

/* rtl/brwt_ram.sv */
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module brwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/byte_ram_with_timer_mmio_top_tb.sv */
// Self-checking testbench for the byte RAM with memory-mapped timer access port.
`timescale 1ns / 1ps

module byte_ram_with_timer_mmio_top_tb;

    localparam int          RAM_BYTES      = 65536;
    localparam int          RESET_CYCLES   = 7;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          PHASE_ITEMS    = 167;
    localparam int          WATCHDOG_LIMIT = 4 * (RAM_BYTES / 4 + 64);
    localparam logic [31:0] TIMER_RESET    = 32'h1000_0000;
    localparam logic [1:0]  KIND_NONE      = 2'd3;
    localparam logic [1:0]  SIZE_WORD      = 2'd2;
    localparam logic [1:0]  SIZE_WIDE      = 2'd3;

    typedef struct packed {
        logic [31:0] read_data;
        logic        stopped;
    } t_port_result;

    class t_ram_timer_predictor;
        bit [7:0]     ram [RAM_BYTES];
        bit [63:0]    cycle_count;
        bit           stop_flag;
        bit [31:0]    timer_base;
        t_port_result expected_results [$];
        int           mismatches;

        function new();
            cycle_count = '0;
            stop_flag   = 1'b0;
            timer_base  = TIMER_RESET;
            mismatches  = 0;
        endfunction

        function void set_timer(input logic [31:0] base);
            timer_base = base;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function bit [7:0] fetch_byte(input bit [31:0] a);
            bit [31:0] off;
            if (a < 32'(RAM_BYTES)) return ram[a];
            off = a - timer_base;
            if (off < 32'd4) return 8'(cycle_count >> {off[1:0], 3'b000});
            return 8'h00;
        endfunction

        function void store_byte(input bit [31:0] a, input bit [7:0] v);
            if (a < 32'(RAM_BYTES)) begin
                ram[a] = v;
            end else if (a == timer_base) begin
                stop_flag = 1'b1;
            end
        endfunction

        function void note_access(input logic [1:0] kind, input logic [31:0] addr,
                                  input logic [1:0] size, input logic [31:0] wdata,
                                  input logic [63:0] cval);
            int           n;
            t_port_result r;
            n = (size == brwt_pkg::SIZE_BYTE) ? 1 : (size == brwt_pkg::SIZE_HALF) ? 2 : 4;
            r.read_data = '0;
            case (kind)
                brwt_pkg::KIND_READ: begin
                    for (int i = 0; i < n; i++)
                        r.read_data[i*8 +: 8] = fetch_byte(addr + 32'(i));
                end
                brwt_pkg::KIND_WRITE: begin
                    for (int i = 0; i < n; i++)
                        store_byte(addr + 32'(i), wdata[i*8 +: 8]);
                end
                brwt_pkg::KIND_LOAD: begin
                    cycle_count = cval;
                end
                default: begin
                end
            endcase
            r.stopped = stop_flag;
            expected_results.push_back(r);
        endfunction

        task check_result(input logic [brwt_pkg::OUT_TDATA_W-1:0] d);
            t_port_result e;
            if (expected_results.size() == 0) begin
                report($sformatf("result %h with no access pending", d));
                return;
            end
            e = expected_results.pop_front();
            if (d[31:0] !== e.read_data)
                report($sformatf("read_data %h, expected %h", d[31:0], e.read_data));
            if (d[32] !== e.stopped)
                report($sformatf("stopped %b, expected %b", d[32], e.stopped));
        endtask
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [31:0]                      cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic [brwt_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                       s_tuser   = '0;
    logic                             m_tready  = 1'b0;
    logic                             cfg_ready;
    logic                             s_tready;
    logic                             m_tvalid;
    logic [brwt_pkg::OUT_TDATA_W-1:0] m_tdata;

    int snd_idle_pct = 22;
    int rcv_idle_pct = 55;
    int idle_cycles  = 0;

    t_ram_timer_predictor port_model;

    byte_ram_with_timer_mmio_top #(
        .RAM_BYTES(RAM_BYTES)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk) begin
        bit moved;
        moved = 1'b0;
        if (s_tvalid && s_tready) begin
            port_model.note_access(s_tuser, s_tdata[31:0], s_tdata[33:32],
                                   s_tdata[65:34], s_tdata[129:66]);
            moved = 1'b1;
        end
        if (cfg_valid && cfg_ready) begin
            port_model.set_timer(cfg_data);
            moved = 1'b1;
        end
        if (m_tvalid && m_tready) begin
            port_model.check_result(m_tdata);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic drive_access(input logic [1:0] kind, input logic [31:0] addr,
                                input logic [1:0] size, input logic [31:0] wdata,
                                input logic [63:0] cval);
        int gap;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, cval, wdata, size, addr};
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (port_model.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timer_address(input logic [31:0] base);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_address();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return 32'($urandom_range(63));
        if (pick < 55) return 32'($urandom_range(RAM_BYTES - 1));
        if (pick < 75) return port_model.timer_base + 32'($urandom_range(9)) - 32'd4;
        if (pick < 85)
            return ((pick < 80) ? 32'd0 : 32'(RAM_BYTES)) + 32'($urandom_range(7)) - 32'd4;
        return $urandom;
    endfunction

    task automatic send_random();
        logic [1:0] kind;
        int         pick;
        pick = $urandom_range(99);
        kind = (pick < 42) ? brwt_pkg::KIND_READ : (pick < 84) ? brwt_pkg::KIND_WRITE :
               (pick < 95) ? brwt_pkg::KIND_LOAD : KIND_NONE;
        drive_access(kind, pick_address(), 2'($urandom_range(3)), $urandom,
                     {$urandom, $urandom});
    endtask

    task automatic run_random_phase(input logic [31:0] base, input int snd_pct,
                                    input int rcv_pct);
        wait_idle();
        write_timer_address(base);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) wait_idle();
            send_random();
        end
    endtask

    initial begin
        port_model = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        drive_access(brwt_pkg::KIND_READ,  32'd0, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_WRITE, 32'd0, SIZE_WORD, 32'hFFFF_FFFF, 64'd0);
        drive_access(brwt_pkg::KIND_WRITE, 32'(RAM_BYTES - 1), brwt_pkg::SIZE_BYTE,
                     32'h0000_00A5, 64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'(RAM_BYTES - 1), SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_WRITE, 32'd2, brwt_pkg::SIZE_HALF, 32'hFFFF_0000,
                     64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'd0, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_LOAD,  32'd0, brwt_pkg::SIZE_BYTE, 32'd0,
                     64'hFFFF_FFFF_FFFF_FFFF);
        drive_access(brwt_pkg::KIND_READ,  TIMER_RESET, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_LOAD,  32'hFFFF_FFFF, SIZE_WIDE, 32'hFFFF_FFFF,
                     64'h0123_4567_89AB_CDEF);
        drive_access(brwt_pkg::KIND_READ,  TIMER_RESET + 32'd1, brwt_pkg::SIZE_HALF,
                     32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_READ,  TIMER_RESET + 32'd2, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_WRITE, TIMER_RESET + 32'd1, SIZE_WORD, 32'hDEAD_BEEF,
                     64'd0);
        drive_access(KIND_NONE,  TIMER_RESET, brwt_pkg::SIZE_BYTE, 32'hFFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFF);
        drive_access(brwt_pkg::KIND_READ,  32'd0, SIZE_WIDE, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'hFFFF_FFFE, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'hFFFF_FFFF, brwt_pkg::SIZE_BYTE, 32'd0,
                     64'd0);

        // timer placed inside RAM
        wait_idle();
        write_timer_address(32'd0);
        drive_access(brwt_pkg::KIND_WRITE, 32'd0, brwt_pkg::SIZE_BYTE, 32'h0000_005A,
                     64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'd0, SIZE_WORD, 32'd0, 64'd0);

        wait_idle();
        write_timer_address(32'hFFFF_FFFF);
        drive_access(brwt_pkg::KIND_READ,  32'hFFFF_FFFF, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'hFFFF_FFFC, SIZE_WORD, 32'd0, 64'd0);

        // timer window wrapping past the top of the address space
        wait_idle();
        write_timer_address(32'hFFFF_FFFE);
        drive_access(brwt_pkg::KIND_LOAD,  32'd0, brwt_pkg::SIZE_BYTE, 32'd0,
                     64'hFEDC_BA98_7654_3210);
        drive_access(brwt_pkg::KIND_READ,  32'hFFFF_FFFE, SIZE_WORD, 32'd0, 64'd0);
        drive_access(brwt_pkg::KIND_WRITE, 32'hFFFF_FFFD, SIZE_WORD, 32'h1122_3344,
                     64'd0);
        drive_access(brwt_pkg::KIND_READ,  32'd16, brwt_pkg::SIZE_BYTE, 32'd0, 64'd0);

        run_random_phase(32'(RAM_BYTES - 2), 22, 55);
        run_random_phase($urandom, 55, 22);
        run_random_phase(TIMER_RESET, 0, 0);
        wait_idle();

        if (port_model.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
